@@ rtl/core/cbm_pkg.sv @@
// cbm_pkg: shared types, codes and constants of the banked cartridge mapper
// used by cbm_ctrl, cbm_datapath and cartridge_bank_mapper_top
`default_nettype none

package cbm_pkg;

  localparam int MAX_BANKS_DEF = 64;
  localparam int BANK_W        = 6;
  localparam int BANK_AW       = 13;
  localparam int RAM_AW        = 8;
  localparam int RAM_BYTES     = 256;
  localparam int CNT_W         = 7;
  localparam int SHIFT_W       = 3;
  localparam int REM_W         = CNT_W + BANK_W - 1;

  localparam int OP_W          = 3;
  localparam int IN_TDATA_W    = 32;
  localparam int OUT_TDATA_W   = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 7;

  localparam logic [SHIFT_W-1:0] MOD_LAST = SHIFT_W'(BANK_W - 1);
  localparam logic [7:0]         BYTE_FF  = 8'hFF;

  typedef enum logic [OP_W-1:0] {
    OP_LOW_RD  = 3'd0,
    OP_HIGH_RD = 3'd1,
    OP_IO_RD   = 3'd2,
    OP_IO_WR   = 3'd3,
    OP_ROM_LD  = 3'd4
  } cbm_op_e;

  typedef enum logic [1:0] {
    CT_PLAIN    = 2'd0,
    CT_BANK     = 2'd1,
    CT_BANK_DIS = 2'd2,
    CT_CTRL_RAM = 2'd3
  } cbm_cart_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CART_TYPE     = 3'd0,
    CFG_BANK_COUNT    = 3'd1,
    CFG_CART_PRESENT  = 3'd2,
    CFG_HAS_HIGH_ROM  = 3'd3,
    CFG_GAME_DEFAULT  = 3'd4,
    CFG_EXROM_DEFAULT = 3'd5
  } cbm_cfg_e;

  localparam logic [BANK_AW-1:0] IO_BANK_OFS = 13'h000;
  localparam logic [BANK_AW-1:0] IO_CTRL_OFS = 13'h002;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_MOD  = 2'd2,
    S_OUT  = 2'd3
  } cbm_state_e;

  typedef struct packed {
    logic               item_load;
    logic               exec;
    logic               mod_step;
    logic [SHIFT_W-1:0] mod_shift;
  } cbm_cmd_t;

  typedef struct packed {
    logic need_mod;
  } cbm_sts_t;

  typedef struct packed {
    logic [BANK_W-1:0] bank_now;
    logic              exrom_level;
    logic              game_level;
    logic [7:0]        rdata;
  } cbm_res_t;

endpackage

`default_nettype wire

@@ rtl/core/cartridge_bank_mapper_top.sv @@
// cartridge_bank_mapper_top: banked cartridge mapper, stream in / stream out
// with a config write channel; depends on cbm_pkg, cbm_ctrl, cbm_datapath
//
// usage:
//   s_axis: one bus access per word; tuser carries the op, tdata the operands
//   m_axis: one result word per access: byte read, line levels, selected bank
//   cfg: register writes (index, data), always ready, only while idle
// sequencing:
//   results are registered in execute, then in the output register; a new
//   word is taken only while idle or as the last result is loaded; an io
//   write with a nonzero bank count runs the bank wrap remainder unit, one
//   quotient bit a cycle; roms and io ram are single port, read at accept
// reset:
//   bank 0, cartridge enabled, GAME and EXROM released, io ram reads zero
//   through per-byte valid flags with no clearing pass; rom contents are kept
// stall:
//   a result waits in the output register; one more word is accepted and
//   worked up to its result, then s_axis_tready stays low until m_axis drains
`default_nettype none

module cartridge_bank_mapper_top #(
  parameter int MAX_BANKS = cbm_pkg::MAX_BANKS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // addr[12:0], load_bank[18:13], load_high[19], wdata[27:20], zero[31:28]
  input  logic [cbm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // op[2:0]
  input  logic [cbm_pkg::OP_W-1:0]         s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // rdata[7:0], game_level[8], exrom_level[9], bank_now[15:10]
  output logic [cbm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [cbm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [cbm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import cbm_pkg::*;

  cbm_cmd_t cmd;
  cbm_sts_t sts;
  cbm_res_t res;
  logic     out_free, out_load;
  logic     m_valid_q;
  logic [OUT_TDATA_W-1:0] m_data_q;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !m_valid_q || m_axis_tready;

  cbm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cbm_datapath #(
    .MAX_BANKS (MAX_BANKS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_op_i        (s_axis_tuser),
    .in_addr_i      (s_axis_tdata[12:0]),
    .in_load_bank_i (s_axis_tdata[18:13]),
    .in_load_high_i (s_axis_tdata[19]),
    .in_wdata_i     (s_axis_tdata[27:20]),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .res_o          (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) m_data_q <= res;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_no_back_to_back_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("word accepted in the execute cycle");

  a_no_result_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !out_load)
    else $error("result loaded before its word was executed");

  a_load_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!m_valid_q || m_axis_tready))
    else $error("output register overwritten while held");

  a_drop_only_on_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(m_valid_q) |-> $past(m_axis_tready))
    else $error("result dropped without handshake");

endmodule

`default_nettype wire

@@ rtl/core/cbm_ctrl.sv @@
// cbm_ctrl: sequencer of the mapper, accept / execute / bank wrap / output
// depends on cbm_pkg; drives cbm_datapath through cbm_cmd_t
`default_nettype none

module cbm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            out_free_i,
  output logic            out_load_o,
  input  cbm_pkg::cbm_sts_t sts_i,
  output cbm_pkg::cbm_cmd_t cmd_o
);
  import cbm_pkg::*;

  cbm_state_e         state_q, state_d;
  logic [SHIFT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    cmd_o     = '0;
    cmd_o.mod_shift = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.item_load = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.need_mod) begin
          cnt_d   = MOD_LAST;
          state_d = S_MOD;
        end else begin
          state_d = S_OUT;
        end
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_OUT;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_OUT: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            cmd_o.item_load = 1'b1;
            state_d = S_EXEC;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/cbm_datapath.sv @@
// cbm_datapath: config and mapper registers, ROM and I/O RAM stores,
// bit-serial bank wrap remainder; depends on cbm_pkg, commanded by cbm_ctrl
`default_nettype none

module cbm_datapath #(
  parameter int MAX_BANKS = cbm_pkg::MAX_BANKS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cbm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cbm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [cbm_pkg::OP_W-1:0]       in_op_i,
  input  logic [cbm_pkg::BANK_AW-1:0]    in_addr_i,
  input  logic [cbm_pkg::BANK_W-1:0]     in_load_bank_i,
  input  logic                           in_load_high_i,
  input  logic [7:0]                     in_wdata_i,
  input  cbm_pkg::cbm_cmd_t              cmd_i,
  output cbm_pkg::cbm_sts_t              sts_o,
  output cbm_pkg::cbm_res_t              res_o
);
  import cbm_pkg::*;

  localparam int BankIw   = (MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1;
  localparam int RomAw    = BankIw + BANK_AW;
  localparam int RomDepth = MAX_BANKS * (2 ** BANK_AW);

  // configuration
  cbm_cart_e        cart_type_q;
  logic [CNT_W-1:0] bank_count_q;
  logic             present_q;
  logic             high_q;

  // mapper state
  logic [BANK_W-1:0] bank_q, bank_d;
  logic              en_q, en_d;
  logic              game_q, game_d;
  logic              exrom_q, exrom_d;
  logic [7:0]        rdata_q, rdata_d;

  // registered item
  cbm_op_e           op_q;
  logic [BANK_AW-1:0] addr_q;
  logic [BANK_W-1:0] lbank_q;
  logic              lhigh_q;
  logic [7:0]        wdata_q;

  // stores
  logic [7:0]           low_mem  [RomDepth];
  logic [7:0]           high_mem [RomDepth];
  logic [7:0]           ram_mem  [RAM_BYTES];
  logic [RAM_BYTES-1:0] ram_vld_q;
  logic [7:0]           low_rd_q, high_rd_q, ram_rd_q;
  logic                 ram_vld_rd_q;

  logic [CNT_W-1:0] n_eff;
  logic             bank_ok;
  logic [RomAw-1:0] rom_ra, rom_wa;
  logic             load_ok, low_we, high_we, ram_we;
  logic [REM_W-1:0] rem, div;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cart_type_q  <= CT_PLAIN;
      bank_count_q <= '0;
      present_q    <= 1'b0;
      high_q       <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CART_TYPE:    cart_type_q  <= cbm_cart_e'(cfg_data_i[1:0]);
        CFG_BANK_COUNT:   bank_count_q <= cfg_data_i;
        CFG_CART_PRESENT: present_q    <= cfg_data_i[0];
        CFG_HAS_HIGH_ROM: high_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign n_eff   = (bank_count_q > CNT_W'(MAX_BANKS)) ? CNT_W'(MAX_BANKS) : bank_count_q;
  assign bank_ok = present_q && en_q && ({1'b0, bank_q} < n_eff);
  assign sts_o.need_mod = (op_q == OP_IO_WR) && (n_eff != '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      op_q    <= cbm_op_e'(in_op_i);
      addr_q  <= in_addr_i;
      lbank_q <= in_load_bank_i;
      lhigh_q <= in_load_high_i;
      wdata_q <= in_wdata_i;
    end
  end

  // roms: read at accept, loaded during execute
  assign rom_ra  = {bank_q[BankIw-1:0], in_addr_i};
  assign rom_wa  = {lbank_q[BankIw-1:0], addr_q};
  assign load_ok = cmd_i.exec && (op_q == OP_ROM_LD) && ({1'b0, lbank_q} < CNT_W'(MAX_BANKS));
  assign low_we  = load_ok && !lhigh_q;
  assign high_we = load_ok && lhigh_q;

  always_ff @(posedge clk_i) begin
    if (low_we) low_mem[rom_wa] <= wdata_q;
    if (cmd_i.item_load) low_rd_q <= low_mem[rom_ra];
  end

  always_ff @(posedge clk_i) begin
    if (high_we) high_mem[rom_wa] <= wdata_q;
    if (cmd_i.item_load) high_rd_q <= high_mem[rom_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) ram_mem[addr_q[RAM_AW-1:0]] <= wdata_q;
    if (cmd_i.item_load) begin
      ram_rd_q     <= ram_mem[in_addr_i[RAM_AW-1:0]];
      ram_vld_rd_q <= ram_vld_q[in_addr_i[RAM_AW-1:0]];
    end
  end

  // unwritten ram entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_vld_q <= '0;
    end else if (ram_we) begin
      ram_vld_q[addr_q[RAM_AW-1:0]] <= 1'b1;
    end
  end

  // restoring remainder, one quotient bit per step
  assign rem = REM_W'(bank_q);
  assign div = REM_W'(n_eff) << cmd_i.mod_shift;

  always_comb begin
    bank_d  = bank_q;
    en_d    = en_q;
    game_d  = game_q;
    exrom_d = exrom_q;
    ram_we  = 1'b0;
    if (cmd_i.exec && (op_q == OP_IO_WR)) begin
      case (cart_type_q)
        CT_BANK: bank_d = wdata_q[BANK_W-1:0];
        CT_BANK_DIS: begin
          bank_d  = wdata_q[BANK_W-1:0];
          en_d    = !wdata_q[7];
          exrom_d = wdata_q[7];
        end
        CT_CTRL_RAM: begin
          if (addr_q == IO_BANK_OFS) begin
            bank_d = wdata_q[BANK_W-1:0];
          end else if (addr_q == IO_CTRL_OFS) begin
            exrom_d = !wdata_q[1];
            game_d  = wdata_q[2] & wdata_q[0];
          end else if (addr_q[BANK_AW-1:RAM_AW] != '0) begin
            ram_we = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (cmd_i.mod_step && (rem >= div)) begin
      bank_d = BANK_W'(rem - div);
    end
  end

  always_comb begin
    rdata_d = BYTE_FF;
    case (op_q)
      OP_LOW_RD:  rdata_d = bank_ok ? low_rd_q : BYTE_FF;
      OP_HIGH_RD: rdata_d = (high_q && bank_ok) ? high_rd_q : BYTE_FF;
      OP_IO_RD: begin
        if ((cart_type_q == CT_CTRL_RAM) && (addr_q[BANK_AW-1:RAM_AW] != '0)) begin
          rdata_d = ram_vld_rd_q ? ram_rd_q : 8'h00;
        end
      end
      default: rdata_d = BYTE_FF;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) rdata_q <= rdata_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q  <= '0;
      en_q    <= 1'b1;
      game_q  <= 1'b1;
      exrom_q <= 1'b1;
    end else begin
      bank_q  <= bank_d;
      en_q    <= en_d;
      game_q  <= game_d;
      exrom_q <= exrom_d;
    end
  end

  assign res_o.bank_now    = bank_q;
  assign res_o.exrom_level = exrom_q;
  assign res_o.game_level  = game_q;
  assign res_o.rdata       = rdata_q;

endmodule

`default_nettype wire

@@ test/cbm_access_checker.sv @@
// cbm_access_checker: predicts every result word of cartridge_bank_mapper_top and
// compares it with the m_axis output, tracking config writes; depends on cbm_pkg
`timescale 1ns / 100ps

module cbm_access_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            acc_valid_i,
  input  logic                            acc_ready_i,
  input  logic [cbm_pkg::IN_TDATA_W-1:0]  acc_data_i,
  input  logic [cbm_pkg::OP_W-1:0]        acc_op_i,
  input  logic                            res_valid_i,
  input  logic                            res_ready_i,
  input  logic [cbm_pkg::OUT_TDATA_W-1:0] res_data_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [cbm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [cbm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output int unsigned                     errors_o,
  output int unsigned                     pending_o
);
  import cbm_pkg::*;

  cbm_cart_e   cart_type;
  logic [6:0]  bank_count;
  logic        cart_present;
  logic        has_high;
  logic        game_dflt;
  logic        exrom_dflt;

  logic [5:0]  bank_sel;
  logic        cart_on;
  logic        game_line;
  logic        exrom_line;
  logic [7:0]  io_ram [RAM_BYTES];
  logic [7:0]  low_rom [int unsigned];
  logic [7:0]  high_rom [int unsigned];

  cbm_res_t    results_q [$];
  cbm_res_t    want;
  cbm_res_t    got;
  int unsigned errors;

  function automatic int unsigned loaded_banks();
    return (bank_count > MAX_BANKS_DEF) ? MAX_BANKS_DEF : bank_count;
  endfunction

  function automatic logic [7:0] window_byte(logic high_win, logic [12:0] ofs);
    int unsigned idx;
    idx = 32'({bank_sel, ofs});
    if (!cart_present || !cart_on || bank_sel >= loaded_banks()) return BYTE_FF;
    return high_win ? high_rom[idx] : low_rom[idx];
  endfunction

  function automatic void io_write(logic [12:0] ofs, logic [7:0] val);
    int unsigned n;
    case (cart_type)
      CT_BANK: bank_sel = val[5:0];
      CT_BANK_DIS: begin
        bank_sel   = val[5:0];
        cart_on    = !val[7];
        exrom_line = val[7];
      end
      CT_CTRL_RAM: begin
        if (ofs == IO_BANK_OFS) begin
          bank_sel = val[5:0];
        end else if (ofs == IO_CTRL_OFS) begin
          exrom_line = !val[1];
          game_line  = val[2] ? val[0] : 1'b0;
        end else if (ofs >= 13'h100) begin
          io_ram[ofs[7:0]] = val;
        end
      end
      default: ;
    endcase
    n = loaded_banks();
    if (n != 0) bank_sel = 6'(bank_sel % n);
  endfunction

  function automatic cbm_res_t apply_access(logic [OP_W-1:0] op,
                                            logic [IN_TDATA_W-1:0] word);
    cbm_res_t    r;
    logic [12:0] ofs;
    logic [5:0]  lbank;
    logic        lhigh;
    logic [7:0]  wbyte;
    ofs   = word[12:0];
    lbank = word[18:13];
    lhigh = word[19];
    wbyte = word[27:20];
    r.rdata = BYTE_FF;
    case (op)
      OP_LOW_RD:  r.rdata = window_byte(1'b0, ofs);
      OP_HIGH_RD: if (has_high) r.rdata = window_byte(1'b1, ofs);
      OP_IO_RD:   if (cart_type == CT_CTRL_RAM && ofs >= 13'h100) r.rdata = io_ram[ofs[7:0]];
      OP_IO_WR:   io_write(ofs, wbyte);
      OP_ROM_LD: begin
        if (lhigh) high_rom[32'({lbank, ofs})] = wbyte;
        else low_rom[32'({lbank, ofs})] = wbyte;
      end
      default: ;
    endcase
    r.game_level  = game_line;
    r.exrom_level = exrom_line;
    r.bank_now    = bank_sel;
    return r;
  endfunction

  task automatic check_field(string what, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cart_type    = CT_PLAIN;
      bank_count   = '0;
      cart_present = 1'b0;
      has_high     = 1'b0;
      game_dflt    = 1'b1;
      exrom_dflt   = 1'b1;
      bank_sel     = '0;
      cart_on      = 1'b1;
      game_line    = game_dflt;
      exrom_line   = exrom_dflt;
      for (int i = 0; i < RAM_BYTES; i++) io_ram[i] = '0;
      results_q.delete();
      errors = 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        got = res_data_i;
        if (results_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word, expected none, actual %h", $time, res_data_i);
        end else begin
          want = results_q.pop_front();
          check_field("rdata", want.rdata, got.rdata);
          check_field("game_level", 8'(want.game_level), 8'(got.game_level));
          check_field("exrom_level", 8'(want.exrom_level), 8'(got.exrom_level));
          check_field("bank_now", 8'(want.bank_now), 8'(got.bank_now));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_CART_TYPE:     cart_type    = cbm_cart_e'(cfg_data_i[1:0]);
          CFG_BANK_COUNT:    bank_count   = cfg_data_i;
          CFG_CART_PRESENT:  cart_present = cfg_data_i[0];
          CFG_HAS_HIGH_ROM:  has_high     = cfg_data_i[0];
          CFG_GAME_DEFAULT:  game_dflt    = cfg_data_i[0];
          CFG_EXROM_DEFAULT: exrom_dflt   = cfg_data_i[0];
          default: ;
        endcase
      end
      if (acc_valid_i && acc_ready_i)
        results_q.insert(results_q.size(), apply_access(acc_op_i, acc_data_i));
    end
    pending_o <= results_q.size();
    errors_o  <= errors;
  end

endmodule

@@ test/tb_cartridge_bank_mapper_top.sv @@
// tb_cartridge_bank_mapper_top: stimulus and verdict for cartridge_bank_mapper_top;
// loads rom banks, runs directed and random access phases under several configs
// depends on cbm_pkg, cartridge_bank_mapper_top and cbm_access_checker
`timescale 1ns / 100ps

module tb_cartridge_bank_mapper_top;
  import cbm_pkg::*;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [OP_W-1:0]        s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  int unsigned            errors;
  int unsigned            pending;
  bit                     tx_gaps;
  bit                     rx_stalls;
  int unsigned            hold_cnt;
  cbm_cart_e              cur_type;
  logic [12:0]            rom_ofs [4];

  cartridge_bank_mapper_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  cbm_access_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_valid_i (s_axis_tvalid),
    .acc_ready_i (s_axis_tready),
    .acc_data_i  (s_axis_tdata),
    .acc_op_i    (s_axis_tuser),
    .res_valid_i (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_data_i  (m_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    m_axis_tready = 1'b0;
    hold_cnt = 0;
    forever begin
      @(posedge clk_i);
      if (rx_stalls && hold_cnt == 0 && $urandom_range(0, 5) == 0)
        hold_cnt = $urandom_range(1, 6);
      if (hold_cnt != 0) begin
        m_axis_tready <= 1'b0;
        hold_cnt--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("** cartridge_bank_mapper_top: FAILED **");
    $finish;
  end

  task automatic send_access(logic [2:0] op, logic [12:0] ofs, logic [5:0] lbank,
                             logic lhigh, logic [7:0] wbyte);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'h0, wbyte, lhigh, lbank, ofs};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(cbm_cfg_e idx, logic [6:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic set_mode(cbm_cart_e ct, logic [6:0] cnt, bit present, bit high);
    drain();
    write_reg(CFG_CART_TYPE, 7'(ct));
    write_reg(CFG_BANK_COUNT, cnt);
    write_reg(CFG_CART_PRESENT, 7'(present));
    write_reg(CFG_HAS_HIGH_ROM, 7'(high));
    if ($urandom_range(0, 3) == 0) begin
      write_reg(CFG_GAME_DEFAULT, 7'($urandom_range(0, 1)));
      write_reg(CFG_EXROM_DEFAULT, 7'($urandom_range(0, 1)));
    end
    cfg_valid_i <= 1'b0;
    cur_type = ct;
  endtask

  task automatic random_access();
    int unsigned pick;
    logic [2:0]  op;
    logic [12:0] ofs;
    logic [5:0]  lbank;
    logic        lhigh;
    logic [7:0]  wbyte;
    pick  = $urandom_range(0, 99);
    ofs   = 13'($urandom_range(0, 8191));
    lbank = 6'($urandom_range(0, 63));
    lhigh = 1'($urandom_range(0, 1));
    wbyte = 8'($urandom_range(0, 255));
    if (pick < 30) begin
      op  = pick[0] ? OP_HIGH_RD : OP_LOW_RD;
      ofs = rom_ofs[$urandom_range(0, 3)];
    end else if (pick < 45) begin
      op = OP_IO_RD;
      case ($urandom_range(0, 5))
        0, 1, 2: ofs = 13'($urandom_range(256, 511));
        3, 4:    ofs = 13'($urandom_range(0, 255));
        default: ;
      endcase
    end else if (pick < 80) begin
      op = OP_IO_WR;
      case ($urandom_range(0, 9))
        0, 1, 2: ofs = IO_BANK_OFS;
        3, 4:    ofs = IO_CTRL_OFS;
        5, 6, 7: ofs = 13'($urandom_range(256, 511));
        default: ;
      endcase
      if (cur_type == CT_BANK_DIS && $urandom_range(0, 3) != 0) wbyte[7] = 1'b0;
    end else if (pick < 95) begin
      op = OP_ROM_LD;
      if ($urandom_range(0, 1) == 0) ofs = rom_ofs[$urandom_range(0, 3)];
    end else begin
      op = 3'($urandom_range(5, 7));
    end
    send_access(op, ofs, lbank, lhigh, wbyte);
  endtask

  initial begin
    cbm_cart_e   ct;
    logic [6:0]  cnt;
    int unsigned mode;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_CART_TYPE;
    cfg_data_i    = '0;
    tx_gaps       = 1'b1;
    rx_stalls     = 1'b1;
    cur_type      = CT_PLAIN;
    rom_ofs[0]    = 13'h0000;
    rom_ofs[1]    = 13'h1FFF;
    rom_ofs[2]    = 13'h0AAA;
    rom_ofs[3]    = 13'h1555;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // the mapper ignores writes to the default line registers, also at reset
    write_reg(CFG_GAME_DEFAULT, 7'd0);
    write_reg(CFG_EXROM_DEFAULT, 7'd0);
    write_reg(CFG_CART_TYPE, 7'(CT_CTRL_RAM));
    write_reg(CFG_BANK_COUNT, 7'd64);
    write_reg(CFG_CART_PRESENT, 7'd1);
    write_reg(CFG_HAS_HIGH_ROM, 7'd1);
    cfg_valid_i <= 1'b0;
    cur_type = CT_CTRL_RAM;

    // fill the read offsets of every bank in both windows
    for (int k = 0; k < 4; k++)
      for (int b = 0; b < 64; b++)
        for (int w = 0; w < 2; w++)
          send_access(OP_ROM_LD, rom_ofs[k], 6'(b), w[0], 8'($urandom_range(0, 255)));

    set_mode(CT_CTRL_RAM, 7'd4, 1'b1, 1'b1);
    send_access(OP_LOW_RD, 13'h0000, 6'h15, 1'b1, 8'hFF);
    send_access(OP_HIGH_RD, 13'h1FFF, 6'h2A, 1'b0, 8'h00);
    send_access(OP_IO_WR, IO_BANK_OFS, 6'h00, 1'b0, 8'hFF);
    send_access(OP_LOW_RD, 13'h0AAA, 6'h3F, 1'b0, 8'h12);
    send_access(OP_IO_WR, IO_CTRL_OFS, 6'h00, 1'b0, 8'h00);
    send_access(OP_IO_WR, IO_CTRL_OFS, 6'h00, 1'b0, 8'h07);
    send_access(OP_IO_WR, IO_CTRL_OFS, 6'h00, 1'b0, 8'h03);
    send_access(OP_IO_WR, 13'h0001, 6'h00, 1'b0, 8'h55);
    send_access(OP_IO_WR, 13'h01FF, 6'h00, 1'b0, 8'hA5);
    send_access(OP_IO_RD, 13'h01FF, 6'h00, 1'b0, 8'h00);
    send_access(OP_IO_RD, 13'h0100, 6'h00, 1'b0, 8'h00);
    send_access(OP_IO_RD, 13'h0005, 6'h00, 1'b0, 8'h00);
    send_access(3'd5, 13'h1FFF, 6'h3F, 1'b1, 8'hFF);
    send_access(3'd7, 13'h0000, 6'h00, 1'b0, 8'h00);
    send_access(OP_ROM_LD, 13'h0000, 6'h3F, 1'b1, 8'h3C);
    // selected bank now lies beyond the count
    set_mode(CT_CTRL_RAM, 7'd2, 1'b1, 1'b1);
    send_access(OP_LOW_RD, 13'h1555, 6'h00, 1'b0, 8'h00);
    set_mode(CT_BANK_DIS, 7'd64, 1'b1, 1'b1);
    send_access(OP_IO_WR, 13'h0123, 6'h00, 1'b0, 8'h85);
    send_access(OP_LOW_RD, 13'h0000, 6'h00, 1'b0, 8'h00);
    send_access(OP_IO_WR, IO_BANK_OFS, 6'h00, 1'b0, 8'h3F);
    send_access(OP_HIGH_RD, 13'h1555, 6'h00, 1'b0, 8'h00);
    set_mode(CT_PLAIN, 7'd0, 1'b1, 1'b0);
    send_access(OP_IO_WR, IO_BANK_OFS, 6'h00, 1'b0, 8'h3F);
    send_access(OP_HIGH_RD, 13'h0000, 6'h00, 1'b0, 8'h00);
    send_access(OP_LOW_RD, 13'h0000, 6'h00, 1'b0, 8'h00);
    set_mode(CT_BANK, 7'd0, 1'b1, 1'b1);
    send_access(OP_IO_WR, IO_BANK_OFS, 6'h00, 1'b0, 8'h2A);
    set_mode(CT_BANK, 7'd127, 1'b0, 1'b1);
    send_access(OP_LOW_RD, 13'h1FFF, 6'h00, 1'b0, 8'h00);
    set_mode(CT_BANK, 7'd127, 1'b1, 1'b1);
    send_access(OP_LOW_RD, 13'h1FFF, 6'h00, 1'b0, 8'h00);

    for (int p = 0; p < 16; p++) begin
      ct = cbm_cart_e'(p % 4);
      if (p < 8) begin
        case (p)
          0: cnt = 7'd127;
          1: cnt = 7'd1;
          2: cnt = 7'd0;
          3: cnt = 7'd64;
          4: cnt = 7'd3;
          5: cnt = 7'd8;
          6: cnt = 7'd100;
          default: cnt = 7'd2;
        endcase
        set_mode(ct, cnt, 1'b1, $urandom_range(0, 3) != 0);
      end else begin
        ct  = cbm_cart_e'($urandom_range(0, 3));
        cnt = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                          : 7'($urandom_range(1, 8));
        set_mode(ct, cnt, $urandom_range(0, 7) != 0, $urandom_range(0, 3) != 0);
      end
      mode      = (p == 15) ? 0 : $urandom_range(0, 3);
      tx_gaps   = mode[0];
      rx_stalls = mode[1];
      repeat (95) random_access();
    end

    drain();
    if (errors == 0) begin
      $display("** cartridge_bank_mapper_top: PASSED **");
    end else begin
      $display("** cartridge_bank_mapper_top: FAILED **");
    end
    $finish;
  end

endmodule
